// File: hw/rtl/pmfb_pkg.sv
// ----------------------------------------------------------------------------
// pmfb_pkg
// Shared types and constants of the paged monochrome frame buffer engine.
// ----------------------------------------------------------------------------
package pmfb_pkg;

   localparam int OP_W    = 3;
   localparam int COORD_W = 8;
   localparam int PAGE_W  = 3;
   localparam int BYTE_W  = 8;
   // Page number of a point operation: row_y divided by eight.
   localparam int PPAGE_W = COORD_W - 3;

   localparam logic [BYTE_W-1:0] BYTE_ONES  = 8'hFF;
   localparam logic [BYTE_W-1:0] BYTE_ZEROS = 8'h00;

   typedef enum logic [OP_W-1:0] {
      OP_SET_PIXEL    = 3'd0,
      OP_CLEAR_PIXEL  = 3'd1,
      OP_INVERT_PIXEL = 3'd2,
      OP_FILL_ONES    = 3'd3,
      OP_FILL_ZEROS   = 3'd4,
      OP_INVERT_ALL   = 3'd5,
      OP_WRITE_BYTE   = 3'd6,
      OP_READ_BYTE    = 3'd7
   } op_type;

   // Decoded request, handed from the request decoder to the controller.
   typedef struct packed {
      op_type              op;
      logic                off_screen;
      logic [PPAGE_W-1:0]  page;
      logic [COORD_W-1:0]  column;
      logic [BYTE_W-1:0]   mask;
      logic [BYTE_W-1:0]   data;
   } cmd_type;

endpackage

// File: hw/rtl/pmfb_if.sv
// ----------------------------------------------------------------------------
// pmfb_if
// Valid/ready channels of the frame buffer engine: request and response.
// ----------------------------------------------------------------------------
interface pmfb_req_if import pmfb_pkg::*;;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [COORD_W-1:0]  column_x;
   logic [COORD_W-1:0]  row_y;
   logic [PAGE_W-1:0]   page_index;
   logic [BYTE_W-1:0]   byte_data;

   modport source (output valid, operation, column_x, row_y, page_index, byte_data,
                   input ready);
   modport sink (input valid, operation, column_x, row_y, page_index, byte_data,
                 output ready);
endinterface

interface pmfb_rsp_if import pmfb_pkg::*;;
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   byte_value;
   logic                off_screen;

   modport source (output valid, byte_value, off_screen, input ready);
   modport sink (input valid, byte_value, off_screen, output ready);
endinterface

// File: hw/rtl/pmfb_store.sv
// ----------------------------------------------------------------------------
// pmfb_store
// Frame store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pmfb_store import pmfb_pkg::*; #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/pmfb_ctrl.sv
// ----------------------------------------------------------------------------
// pmfb_ctrl
// Sequencer: byte read-modify-write, whole-store sweeps and result register.
// ----------------------------------------------------------------------------
module pmfb_ctrl import pmfb_pkg::*; #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  cmd_type        req_cmd,
   pmfb_rsp_if.source     rsp_ch
);

   localparam int DEPTH = COLUMNS * PAGES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] SWEEP_LAST = CW'(DEPTH - 1);
   localparam logic [CW-1:0] SWEEP_END  = CW'(DEPTH);

   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_ACCESS,
      ST_INVERT,
      ST_HOLD
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     sweep_ff, sweep_in;
   logic [BYTE_W-1:0] fill_ff, fill_in;
   logic              report_ff, report_in;
   op_type            op_ff, op_in;
   logic [BYTE_W-1:0] mask_ff, mask_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [BYTE_W-1:0] res_value_ff, res_value_in;
   logic              res_off_ff, res_off_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_off_ff, rsp_off_in;

   logic              accept;
   logic              out_free;
   logic [AW-1:0]     cmd_addr;
   logic [BYTE_W-1:0] new_byte;
   logic              finish;
   logic [BYTE_W-1:0] finish_value;
   logic              finish_off;

   logic              mem_we;
   logic [AW-1:0]     mem_wa;
   logic [BYTE_W-1:0] mem_wd;
   logic              mem_re;
   logic [AW-1:0]     mem_ra;
   logic [BYTE_W-1:0] mem_rd;

   pmfb_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_en   (mem_re),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign cmd_addr  = AW'(int'(req_cmd.page) * COLUMNS + int'(req_cmd.column));

   always_comb begin
      case (op_ff)
         OP_SET_PIXEL:    new_byte = mem_rd | mask_ff;
         OP_CLEAR_PIXEL:  new_byte = mem_rd & ~mask_ff;
         OP_INVERT_PIXEL: new_byte = mem_rd ^ mask_ff;
         OP_WRITE_BYTE:   new_byte = data_ff;
         default:         new_byte = mem_rd;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      fill_in      = fill_ff;
      report_in    = report_ff;
      op_in        = op_ff;
      mask_in      = mask_ff;
      data_in      = data_ff;
      addr_in      = addr_ff;
      res_value_in = res_value_ff;
      res_off_in   = res_off_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in = rsp_value_ff;
      rsp_off_in   = rsp_off_ff;
      mem_we       = 1'b0;
      mem_wa       = addr_ff;
      mem_wd       = fill_ff;
      mem_re       = 1'b0;
      mem_ra       = cmd_addr;
      finish       = 1'b0;
      finish_value = BYTE_ZEROS;
      finish_off   = 1'b0;

      case (state_ff)
         ST_FILL: begin
            mem_we = 1'b1;
            mem_wa = sweep_ff[AW-1:0];
            if (sweep_ff == SWEEP_LAST) begin
               sweep_in = '0;
               if (report_ff) begin
                  finish = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd.op)
                  OP_FILL_ONES, OP_FILL_ZEROS: begin
                     fill_in   = (req_cmd.op == OP_FILL_ONES) ? BYTE_ONES : BYTE_ZEROS;
                     report_in = 1'b1;
                     sweep_in  = '0;
                     state_in  = ST_FILL;
                  end
                  OP_INVERT_ALL: begin
                     sweep_in = '0;
                     state_in = ST_INVERT;
                  end
                  default: begin
                     if (req_cmd.off_screen) begin
                        finish     = 1'b1;
                        finish_off = 1'b1;
                     end else begin
                        mem_re   = 1'b1;
                        mem_ra   = cmd_addr;
                        op_in    = req_cmd.op;
                        mask_in  = req_cmd.mask;
                        data_in  = req_cmd.data;
                        addr_in  = cmd_addr;
                        state_in = ST_ACCESS;
                     end
                  end
               endcase
            end
         end
         ST_ACCESS: begin
            // Read data arrived this cycle; unless the operation is a byte read, the modified byte goes straight back.
            mem_we       = (op_ff != OP_READ_BYTE);
            mem_wa       = addr_ff;
            mem_wd       = new_byte;
            finish       = 1'b1;
            finish_value = new_byte;
         end
         ST_INVERT: begin
            // Reads run one address ahead of the writes of inverted bytes.
            if (sweep_ff != SWEEP_END) begin
               mem_re  = 1'b1;
               mem_ra  = sweep_ff[AW-1:0];
               addr_in = sweep_ff[AW-1:0];
            end
            if (sweep_ff != '0) begin
               mem_we = 1'b1;
               mem_wa = addr_ff;
               mem_wd = ~mem_rd;
            end
            if (sweep_ff == SWEEP_END) begin
               sweep_in = '0;
               finish   = 1'b1;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_off_in   = res_off_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A finished result goes to the output register if it is free, else it waits.
      if (finish) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_value_in = finish_value;
            rsp_off_in   = finish_off;
            state_in     = ST_IDLE;
         end else begin
            res_value_in = finish_value;
            res_off_in   = finish_off;
            state_in     = ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         sweep_ff     <= '0;
         fill_ff      <= BYTE_ZEROS;
         report_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         fill_ff      <= fill_in;
         report_ff    <= report_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      mask_ff      <= mask_in;
      data_ff      <= data_in;
      addr_ff      <= addr_in;
      res_value_ff <= res_value_in;
      res_off_ff   <= res_off_in;
      rsp_value_ff <= rsp_value_in;
      rsp_off_ff   <= rsp_off_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.byte_value = rsp_value_ff;
   assign rsp_ch.off_screen = rsp_off_ff;

endmodule

// File: hw/rtl/paged_mono_framebuffer_engine.sv
// A point or byte operation reads its byte from the store and, unless it is a byte read, writes
// the new byte back. Off-screen operations skip the store. Fills write each address of the store
// in turn and invert-all reads each byte ahead of its write, limited by the single write port.
// A new request is taken only after the previous result has moved to the response register.
// Reset is synchronous; afterwards a clearing pass zeroes the store
// before the first request is taken.
// ----------------------------------------------------------------------------
// paged_mono_framebuffer_engine
// Paged monochrome frame store with pixel, byte and whole-store operations.
// ----------------------------------------------------------------------------
module paged_mono_framebuffer_engine import pmfb_pkg::*; #(
   parameter int SCREEN_COLUMNS = 128,
   parameter int SCREEN_PAGES   = 8
) (
   input  logic        clock,
   input  logic        reset,
   pmfb_req_if.sink    req_ch,
   pmfb_rsp_if.source  rsp_ch
);

   localparam logic [COORD_W:0]  COL_LIMIT  = (COORD_W+1)'(SCREEN_COLUMNS);
   localparam logic [COORD_W:0]  ROW_LIMIT  = (COORD_W+1)'(8 * SCREEN_PAGES);
   localparam logic [PPAGE_W:0]  PAGE_LIMIT = (PPAGE_W+1)'(SCREEN_PAGES);

   op_type  op;
   logic    point_op;
   logic    col_off;
   cmd_type cmd;

   assign op       = op_type'(req_ch.operation);
   assign point_op = (op inside {OP_SET_PIXEL, OP_CLEAR_PIXEL, OP_INVERT_PIXEL});
   assign col_off  = ({1'b0, req_ch.column_x} >= COL_LIMIT);

   always_comb begin
      cmd.op     = op;
      cmd.column = req_ch.column_x;
      cmd.data   = req_ch.byte_data;
      cmd.mask   = BYTE_W'(1) << req_ch.row_y[2:0];
      if (point_op) begin
         cmd.page       = req_ch.row_y[COORD_W-1:3];
         cmd.off_screen = col_off || ({1'b0, req_ch.row_y} >= ROW_LIMIT);
      end else begin
         cmd.page       = PPAGE_W'(req_ch.page_index);
         cmd.off_screen = col_off ||
                          ((PPAGE_W+1)'(req_ch.page_index) >= PAGE_LIMIT);
      end
   end

   pmfb_ctrl #(
      .COLUMNS (SCREEN_COLUMNS),
      .PAGES   (SCREEN_PAGES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_cmd   (cmd),
      .rsp_ch    (rsp_ch)
   );

endmodule
